[hdl/csda_pkg.sv]
// ----------------------------------------------------------------------------
// csda_pkg
// Shared types and constants of the chi-square distance accumulator.
// ----------------------------------------------------------------------------
package csda_pkg;

  localparam int VALUE_W   = 16;          // bin value width, unsigned fixed point
  localparam int SUM_W     = 48;          // running sum width
  localparam int FRAC_BITS = VALUE_W - 4; // fraction bits of a bin value
  localparam int SUM_FRAC  = 16;          // fraction bits of a term and of the sum

  typedef struct packed {
    logic [VALUE_W-1:0] cur_density;
    logic [VALUE_W-1:0] tar_density;
    logic               last_bin;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] chi2_value;
    logic             saturated;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // take the input item
    logic mult;     // square the difference, pick the divisor
    logic load;     // align the dividend, clear the divider
    logic step;     // two quotient bits
    logic accum;    // add the term, emit on the last bin
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;  // divider is in its final step
    logic last_bin;  // held item closes the histogram
    logic out_busy;  // result register is full and stalled
  } status_t;

endpackage

[hdl/csda_ctrl.sv]
// ----------------------------------------------------------------------------
// csda_ctrl
// Sequencer: accept, square, load, divide, accumulate.
// ----------------------------------------------------------------------------
module csda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  csda_pkg::status_t status,
  output csda_pkg::cmd_t    cmd
);
  import csda_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mult  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) state_nxt = S_ACC;
      end
      S_ACC: begin
        // hold a closing bin while a finished result still waits on the output
        if (!(status.last_bin && status.out_busy)) begin
          cmd.accum = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[hdl/csda_dp.sv]
// ----------------------------------------------------------------------------
// csda_dp
// Datapath: squared difference, radix-4 restoring divider, saturating sum
// and the result register.
// ----------------------------------------------------------------------------
module csda_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  csda_pkg::cmd_t      cmd,
  output csda_pkg::status_t   status,
  input  csda_pkg::in_item_t  in_item,
  input  logic                out_stall,
  output logic                out_valid,
  output csda_pkg::out_item_t out_item
);
  import csda_pkg::*;

  localparam int SQ_W  = 2 * VALUE_W;           // squared difference
  localparam int WD_W  = SQ_W + SUM_FRAC;       // square with term fraction bits
  localparam int N_W   = WD_W - FRAC_BITS + 1;  // dividend, worst case shift
  localparam int ITER  = (N_W + 1) / 2;         // two quotient bits a step
  localparam int Q_W   = 2 * ITER;
  localparam int CNT_W = (ITER > 1) ? $clog2(ITER) : 1;
  localparam int M_W   = (Q_W > SUM_W) ? Q_W : SUM_W;

  // held item
  logic [VALUE_W-1:0] cur_r, tar_r;
  logic               last_r;

  // square stage
  logic [SQ_W-1:0]    sq_r;
  logic [VALUE_W-1:0] div_r;
  logic               use_tar_r;
  logic               zero_r;

  // divider
  logic [Q_W-1:0]     n_r;
  logic [Q_W-1:0]     q_r;
  logic [VALUE_W-1:0] rem_r;
  logic [CNT_W-1:0]   cnt_r;

  // sum
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             ov_r, ov_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r;

  logic [VALUE_W-1:0] diff;
  logic [WD_W-1:0]    wide, n_tar, n_cur;
  logic [VALUE_W:0]   rem_a, rem_b, sub_a, sub_b;
  logic               ge_a, ge_b;
  logic [VALUE_W-1:0] rem_1, rem_2;
  logic [M_W-1:0]     q_ext;
  logic               term_sat;
  logic [SUM_W-1:0]   term;
  logic [SUM_W:0]     sum_ext;

  assign diff = (cur_r >= tar_r) ? (cur_r - tar_r) : (tar_r - cur_r);

  // divisor tar<<FRAC or cur<<(FRAC-1): fold the shift into the dividend
  assign wide  = {sq_r, {SUM_FRAC{1'b0}}};
  assign n_tar = wide >> FRAC_BITS;
  assign n_cur = wide >> (FRAC_BITS - 1);

  always_comb begin
    rem_a = {rem_r, n_r[Q_W-1]};
    ge_a  = (rem_a >= {1'b0, div_r});
    sub_a = rem_a - {1'b0, div_r};
    rem_1 = ge_a ? sub_a[VALUE_W-1:0] : rem_a[VALUE_W-1:0];
    rem_b = {rem_1, n_r[Q_W-2]};
    ge_b  = (rem_b >= {1'b0, div_r});
    sub_b = rem_b - {1'b0, div_r};
    rem_2 = ge_b ? sub_b[VALUE_W-1:0] : rem_b[VALUE_W-1:0];
  end

  always_comb begin
    q_ext    = M_W'(q_r);
    term_sat = !zero_r && (q_ext > M_W'({SUM_W{1'b1}}));
    if (zero_r)        term = '0;
    else if (term_sat) term = {SUM_W{1'b1}};
    else               term = q_ext[SUM_W-1:0];
    sum_ext = {1'b0, sum_r} + {1'b0, term};
    sum_nxt = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    ov_nxt  = ov_r | term_sat | sum_ext[SUM_W];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_r  <= in_item.cur_density;
      tar_r  <= in_item.tar_density;
      last_r <= in_item.last_bin;
    end
    if (cmd.mult) begin
      sq_r      <= diff * diff;
      use_tar_r <= (tar_r != '0);
      div_r     <= (tar_r != '0) ? tar_r : cur_r;
      zero_r    <= (cur_r == '0) && (tar_r == '0);
    end
    if (cmd.load) begin
      n_r   <= use_tar_r ? n_tar[Q_W-1:0] : n_cur[Q_W-1:0];
      q_r   <= '0;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.step) begin
      n_r   <= {n_r[Q_W-3:0], 2'b00};
      q_r   <= {q_r[Q_W-3:0], ge_a, ge_b};
      rem_r <= rem_2;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.accum && last_r) begin
      out_item_r.chi2_value <= sum_nxt;
      out_item_r.saturated  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      ov_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accum) begin
        // clear after the closing bin
        sum_r <= last_r ? '0 : sum_nxt;
        ov_r  <= last_r ? 1'b0 : ov_nxt;
      end
      if (cmd.accum && last_r)     out_valid_r <= 1'b1;
      else if (!out_stall)         out_valid_r <= 1'b0;
    end
  end

  assign status.div_last = (cnt_r == CNT_W'(ITER - 1));
  assign status.last_bin = last_r;
  assign status.out_busy = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[hdl/chi_square_distance_accumulator_top.sv]
// ----------------------------------------------------------------------------
// chi_square_distance_accumulator_top
// Accumulates the chi-square distance of a stream of histogram bins.
//
//   channel  direction  payload      handshake
//   in_      input      in_item_t    in_valid / in_stall
//   out_     output     out_item_t   out_valid / out_stall
//
// Each item runs through accept, square, dividend alignment, the restoring
// divider at two quotient bits a cycle and accumulation; the next item is
// accepted only once the last one has been accumulated.
// Reset (rst_n, synchronous) clears the sum, the saturation flag and the
// result valid flag. A stalled result holds its register; the next bins still
// run and only the closing bin waits for the register to drain.
// ----------------------------------------------------------------------------
module chi_square_distance_accumulator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  csda_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output csda_pkg::out_item_t out_item
);
  import csda_pkg::*;

  cmd_t    cmd;
  status_t status;

  csda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  csda_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[tb/sv/tb_chi_square_distance_accumulator_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chi_square_distance_accumulator_top
// Streams histogram bins into the accumulator and checks every chi-square
// result. A directed table comes first, then random histograms with one long
// histogram of the largest terms. Both channels idle at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_chi_square_distance_accumulator_top;
  import csda_pkg::*;

  localparam int          PERIOD      = 10;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          RAND_BINS   = 1850;
  localparam int          HEAVY_BINS  = 200;
  localparam int          HOLD_CYCLES = 2000;
  localparam int          DRAIN_WAIT  = 60;
  localparam bit [63:0]   SUM_MAX     = (64'd1 << SUM_W) - 64'd1;

  typedef struct packed {
    logic [VALUE_W-1:0] cur;
    logic [VALUE_W-1:0] tar;
    logic               last;
    logic               typed;
    logic [SUM_W-1:0]   val;
    logic               sat;
  } dir_row_t;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t res;
  } bin_rec_t;

  // expected values are typed in only where they follow directly:
  // target zero gives 32*cur, current zero gives 16*tar, in Q16
  localparam dir_row_t DIRECTED [20] = '{
    '{16'h0000, 16'h0000, 1'b1, 1'b1, 48'd0,       1'b0},
    '{16'hFFFF, 16'h0000, 1'b1, 1'b1, 48'd2097120, 1'b0},
    '{16'h0000, 16'hFFFF, 1'b1, 1'b1, 48'd1048560, 1'b0},
    '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 48'd0,       1'b0},
    '{16'h0001, 16'h0000, 1'b1, 1'b1, 48'd32,      1'b0},
    '{16'h0000, 16'h0001, 1'b1, 1'b1, 48'd16,      1'b0},
    '{16'hFFFF, 16'h0001, 1'b1, 1'b0, 48'd0,       1'b0},
    '{16'h0001, 16'hFFFF, 1'b1, 1'b0, 48'd0,       1'b0},
    '{16'h1000, 16'h1000, 1'b0, 1'b0, 48'd0,       1'b0},
    '{16'h2000, 16'h1000, 1'b0, 1'b0, 48'd0,       1'b0},
    '{16'h0000, 16'h0000, 1'b0, 1'b0, 48'd0,       1'b0},
    '{16'h0800, 16'h0000, 1'b1, 1'b0, 48'd0,       1'b0},
    '{16'd12345, 16'd54321, 1'b0, 1'b0, 48'd0,     1'b0},
    '{16'hFFFF, 16'h0001, 1'b0, 1'b0, 48'd0,       1'b0},
    '{16'h0000, 16'h0000, 1'b1, 1'b0, 48'd0,       1'b0},
    '{16'h8000, 16'h0001, 1'b1, 1'b0, 48'd0,       1'b0},
    '{16'h0001, 16'h8000, 1'b1, 1'b0, 48'd0,       1'b0},
    '{16'hAAAA, 16'h5555, 1'b1, 1'b0, 48'd0,       1'b0},
    '{16'h5555, 16'hAAAA, 1'b1, 1'b0, 48'd0,       1'b0},
    '{16'hFFFF, 16'hFFFE, 1'b1, 1'b0, 48'd0,       1'b0}
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  chi_square_distance_accumulator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  bin_rec_t         bins_q[$];
  out_item_t        chi2_due[$];
  int               bins_taken;
  int               mismatches;
  int               cyc;
  logic             hold_off;
  logic             quiet;
  bit [SUM_W-1:0]   chi_sum;
  bit               sat_seen;

  assign quiet = (cyc >= 30000) && (cyc < 50000);

  initial begin
    clk = 1'b0;
    forever #(PERIOD / 2) clk = ~clk;
  end

  // one term of the distance, Q16, truncated; clamp flags saturation
  task automatic chi_term(input logic [VALUE_W-1:0] cur, input logic [VALUE_W-1:0] tar,
                          output bit [63:0] term, output bit clamp);
    bit [63:0] d;
    bit [63:0] num;
    bit [63:0] den;
    term  = 64'd0;
    clamp = 1'b0;
    if (cur != 0 || tar != 0) begin
      d   = (cur >= tar) ? 64'(cur - tar) : 64'(tar - cur);
      num = d * d;
      den = (tar != 0) ? (64'(tar) << FRAC_BITS) : (64'(cur) << (FRAC_BITS - 1));
      term = (num << SUM_FRAC) / den;
      if (term > SUM_MAX) begin
        term  = SUM_MAX;
        clamp = 1'b1;
      end
    end
  endtask

  // fold one bin into the running distance; a closing bin yields a result
  task automatic fold_bin(input in_item_t b, output bit has_res, output out_item_t res);
    bit [63:0] term;
    bit        clamp;
    chi_term(b.cur_density, b.tar_density, term, clamp);
    if (clamp) sat_seen = 1'b1;
    if (term > SUM_MAX - 64'(chi_sum)) begin
      chi_sum  = SUM_MAX[SUM_W-1:0];
      sat_seen = 1'b1;
    end else begin
      chi_sum = chi_sum + term[SUM_W-1:0];
    end
    has_res        = b.last_bin;
    res.chi2_value = chi_sum;
    res.saturated  = sat_seen;
    if (b.last_bin) begin
      chi_sum  = '0;
      sat_seen = 1'b0;
    end
  endtask

  function automatic logic [VALUE_W-1:0] rand_density();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0:       return '0;
      1:       return '1;
      2:       return VALUE_W'($urandom_range(1, 15));
      3:       return VALUE_W'($urandom_range(16'hFFF0, 16'hFFFF));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic push_bin(input logic [VALUE_W-1:0] cur, input logic [VALUE_W-1:0] tar,
                          input logic last);
    bin_rec_t r;
    r.item.cur_density = cur;
    r.item.tar_density = tar;
    r.item.last_bin    = last;
    r.typed            = 1'b0;
    r.res              = '0;
    bins_q.push_back(r);
  endtask

  // heavy histograms use the largest term so the sum grows fast
  task automatic push_hist(input int nbins, input bit heavy);
    logic [VALUE_W-1:0] cur;
    logic [VALUE_W-1:0] tar;
    int                 pat;
    for (int i = 0; i < nbins; i++) begin
      if (heavy) begin
        cur = '1;
        tar = VALUE_W'(1);
      end else begin
        pat = $urandom_range(0, 9);
        cur = rand_density();
        tar = rand_density();
        case (pat)
          0: tar = cur;
          1: tar = '0;
          2: cur = '0;
          3: begin
            cur = '0;
            tar = '0;
          end
          default: ;
        endcase
      end
      push_bin(cur, tar, i == nbins - 1);
    end
  endtask

  task automatic build_stimulus();
    bin_rec_t r;
    int       n_rand;
    int       len;
    foreach (DIRECTED[i]) begin
      r.item.cur_density = DIRECTED[i].cur;
      r.item.tar_density = DIRECTED[i].tar;
      r.item.last_bin    = DIRECTED[i].last;
      r.typed            = DIRECTED[i].typed;
      r.res.chi2_value   = DIRECTED[i].val;
      r.res.saturated    = DIRECTED[i].sat;
      bins_q.push_back(r);
    end
    n_rand = 0;
    while (n_rand < RAND_BINS) begin
      if (n_rand >= RAND_BINS / 2 && n_rand - RAND_BINS / 2 < 24) begin
        push_hist(HEAVY_BINS, 1'b1);
        n_rand = n_rand + HEAVY_BINS;
      end
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      push_hist(len, 1'b0);
      n_rand = n_rand + len;
    end
  endtask

  // result check, receiver stall and sender in one process, all on one edge
  always @(posedge clk) begin
    out_item_t want;
    out_item_t res;
    bit        got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (chi2_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: chi2=%0d sat=%0b", out_item.chi2_value,
                     out_item.saturated);
        end else begin
          want = chi2_due.pop_front();
          if (out_item.chi2_value !== want.chi2_value ||
              out_item.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected chi2=%0d sat=%0b, got chi2=%0d sat=%0b",
                       want.chi2_value, want.saturated, out_item.chi2_value,
                       out_item.saturated);
          end
        end
      end
      out_stall <= hold_off || (!quiet && $urandom_range(0, 99) < 14);

      if (in_valid && !in_stall) begin
        fold_bin(bins_q[bins_taken].item, got, res);
        if (got) chi2_due.push_back(bins_q[bins_taken].typed ? bins_q[bins_taken].res : res);
        bins_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (bins_taken < bins_q.size() && (quiet || $urandom_range(0, 99) >= 14)) begin
          in_valid <= 1'b1;
          in_item  <= bins_q[bins_taken].item;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    hold_off = 1'b0;
    while (bins_taken < 300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("tb_chi_square_distance_accumulator_top failed");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    out_stall  = 1'b0;
    bins_taken = 0;
    mismatches = 0;
    cyc        = 0;
    chi_sum    = '0;
    sat_seen   = 1'b0;
    build_stimulus();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (bins_taken < bins_q.size() || chi2_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && chi2_due.size() == 0) begin
      $display("tb_chi_square_distance_accumulator_top passed");
    end else begin
      $display("tb_chi_square_distance_accumulator_top failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/csda_pkg.sv
hdl/csda_ctrl.sv
hdl/csda_dp.sv
hdl/chi_square_distance_accumulator_top.sv
tb/sv/tb_chi_square_distance_accumulator_top.sv
